>>> rtl/gsdc_pkg.sv
// Shared types, constants and calendar tables for the Gregorian serial day converter.
`timescale 1ns / 1ps
`default_nettype none
package gsdc_pkg;

   localparam int unsigned DATA_STAGES = 8;
   localparam int unsigned NUM_STAGES  = DATA_STAGES + 1;

   localparam int unsigned STATUS_W = 2;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned SERIAL_W = 22;

   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_DATE   = 2'd1,
      STATUS_BAD_SERIAL = 2'd2
   } status_type;

   localparam int unsigned BASE_YEAR         = 1601;
   localparam int unsigned MONTHS            = 12;
   localparam int unsigned YEARS_100         = 100;
   localparam int unsigned YEARS_400         = 400;
   localparam int unsigned QUADS_PER_CENTURY = 25;
   localparam int unsigned DAYS_1            = 365;
   localparam int unsigned DAYS_4            = 1461;
   localparam int unsigned DAYS_100          = 36524;
   localparam int unsigned DAYS_400          = 146097;

   // Floor reciprocals; quotient estimates are low by at most one
   localparam int unsigned RECIP_100_SHIFT = 24;
   localparam int unsigned RECIP_4Y_SHIFT  = 32;
   localparam int unsigned RECIP_400Y_SHIFT = 40;
   localparam logic [17:0] RECIP_100  = 18'((64'd1 << RECIP_100_SHIFT) / 64'd100);
   localparam logic [21:0] RECIP_4Y   = 22'((64'd1 << RECIP_4Y_SHIFT) / 64'd1461);
   localparam logic [22:0] RECIP_400Y = 23'((64'd1 << RECIP_400Y_SHIFT) / 64'd146097);

   typedef struct packed {
      logic                bad;
      logic [SERIAL_W-1:0] serial;
   } enc_result_type;

   typedef struct packed {
      logic               bad;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } dec_result_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         4'd2: begin
            days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = 5'd30;
         end
         default: begin
            days = 5'd31;
         end
      endcase
      return days;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      if (leap && month > 4'd2 && month < 4'd13) begin
         days = days + 9'd1;
      end
      return days;
   endfunction

endpackage
`default_nettype wire

>>> rtl/gregorian_serial_day_converter_top.sv
// Top level of the Gregorian serial day converter: handshake, stage valids, result register.
//
// Converts between a Gregorian date and a serial day number (1 January 1601 is day 1).
// Request channel (req_): req_type selects encode (date to serial) or decode (serial
// to date); the fields the chosen direction does not use are ignored.
// Response channel (rsp_): one result per request, in request order, with
// rsp_status OK, invalid date (encode) or serial out of range (decode); fields of
// the unused direction and all fields of an error result are zero.
// A request transfer loads the first of eight datapath stages (two constant-reciprocal
// divisions, each with a correction stage, then the year split and the month search);
// the result register follows them.
// Throughput: one transfer per cycle in each direction while rsp_ready stays high.
// Each stage holds its item while the stage after it is full and stalled, so a
// stalled receiver fills empty stages first; req_ready drops only once every
// stage holds an item. Nothing is lost or repeated across a stall.
// Reset clears every stage valid; the block takes a request on the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_serial_day_converter_top #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_type,
   input  wire logic [gsdc_pkg::DAY_W-1:0]        req_day_in,
   input  wire logic [gsdc_pkg::MONTH_W-1:0]      req_month_in,
   input  wire logic [gsdc_pkg::YEAR_W-1:0]       req_year_in,
   input  wire logic [gsdc_pkg::SERIAL_W-1:0]     req_serial_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gsdc_pkg::STATUS_W-1:0]          rsp_status,
   output logic [gsdc_pkg::SERIAL_W-1:0]          rsp_serial_out,
   output logic [gsdc_pkg::DAY_W-1:0]             rsp_day_out,
   output logic [gsdc_pkg::MONTH_W-1:0]           rsp_month_out,
   output logic [gsdc_pkg::YEAR_W-1:0]            rsp_year_out
);

   localparam int unsigned LAST = gsdc_pkg::NUM_STAGES;
   localparam int unsigned DATA = gsdc_pkg::DATA_STAGES;

   logic [LAST:1]  en;
   logic [LAST:1]  valid_ff;
   logic [DATA:1]  type_ff;

   gsdc_pkg::enc_result_type enc_result;
   gsdc_pkg::dec_result_type dec_result;

   gsdc_pkg::status_type                status_in;
   logic [gsdc_pkg::SERIAL_W-1:0]       serial_in;
   logic [gsdc_pkg::DAY_W-1:0]          day_in;
   logic [gsdc_pkg::MONTH_W-1:0]        month_in;
   logic [gsdc_pkg::YEAR_W-1:0]         year_in;

   gsdc_pkg::status_type                status_ff;
   logic [gsdc_pkg::SERIAL_W-1:0]       serial_ff;
   logic [gsdc_pkg::DAY_W-1:0]          day_ff;
   logic [gsdc_pkg::MONTH_W-1:0]        month_ff;
   logic [gsdc_pkg::YEAR_W-1:0]         year_ff;

   always_comb begin
      en[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= LAST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         type_ff[1] <= req_type;
      end
      for (int k = 2; k <= DATA; k++) begin
         if (en[k]) begin
            type_ff[k] <= type_ff[k-1];
         end
      end
   end

   gsdc_encode #(
      .MAX_YEAR (MAX_YEAR)
   ) u_encode (
      .clock    (clock),
      .en       (en[DATA:1]),
      .day_in   (req_day_in),
      .month_in (req_month_in),
      .year_in  (req_year_in),
      .result   (enc_result)
   );

   gsdc_decode #(
      .MAX_YEAR (MAX_YEAR)
   ) u_decode (
      .clock     (clock),
      .en        (en[DATA:1]),
      .serial_in (req_serial_in),
      .result    (dec_result)
   );

   always_comb begin
      if (type_ff[DATA] == gsdc_pkg::REQ_DECODE) begin
         status_in = dec_result.bad ? gsdc_pkg::STATUS_BAD_SERIAL : gsdc_pkg::STATUS_OK;
         serial_in = '0;
         day_in    = dec_result.day;
         month_in  = dec_result.month;
         year_in   = dec_result.year;
      end else begin
         status_in = enc_result.bad ? gsdc_pkg::STATUS_BAD_DATE : gsdc_pkg::STATUS_OK;
         serial_in = enc_result.serial;
         day_in    = '0;
         month_in  = '0;
         year_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         status_ff <= status_in;
         serial_ff <= serial_in;
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
      end
   end

   assign rsp_valid      = valid_ff[LAST];
   assign rsp_status     = status_ff;
   assign rsp_serial_out = serial_ff;
   assign rsp_day_out    = day_ff;
   assign rsp_month_out  = month_ff;
   assign rsp_year_out   = year_ff;

endmodule
`default_nettype wire

>>> rtl/gsdc_encode.sv
// Date to serial day number pipeline with Gregorian date validation.
`timescale 1ns / 1ps
`default_nettype none
module gsdc_encode #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  wire logic                                clock,
   input  wire logic [gsdc_pkg::DATA_STAGES:1]      en,
   input  wire logic [gsdc_pkg::DAY_W-1:0]          day_in,
   input  wire logic [gsdc_pkg::MONTH_W-1:0]        month_in,
   input  wire logic [gsdc_pkg::YEAR_W-1:0]         year_in,
   output gsdc_pkg::enc_result_type                 result
);

   localparam logic [16:0] MAX_YEAR_W = 17'(MAX_YEAR);
   localparam logic [13:0] BASE       = 14'(gsdc_pkg::BASE_YEAR);
   localparam logic [13:0] CENTURY    = 14'(gsdc_pkg::YEARS_100);

   // stage 1
   logic [4:0]  day1_ff;
   logic [3:0]  month1_ff;
   logic [13:0] year1_ff;

   // stage 2
   logic [13:0] dy2_in;
   logic [31:0] yprod2_in, dprod2_in;
   logic        month_ok2_in, year_ok2_in;
   logic [4:0]  day2_ff;
   logic [3:0]  month2_ff;
   logic [13:0] year2_ff, dy2_ff;
   logic [31:0] yprod2_ff, dprod2_ff;
   logic        month_ok2_ff, year_ok2_ff;

   // stage 3
   logic [7:0]  yq_est, yq, dq_est, dq3_in;
   logic [13:0] yrem_est, drem_est;
   logic [13:0] yrem;
   logic        leap3_in, valid3_in;
   logic        leap3_ff, valid3_ff;
   logic [3:0]  month3_ff;
   logic [4:0]  day3_ff;
   logic [13:0] dy3_ff;
   logic [7:0]  dq3_ff;

   // stage 4
   logic [22:0] base4_in, base4_ff;
   logic [8:0]  doy4_in, doy4_ff;
   logic        valid4_ff;

   // stages 5 to 8
   logic [22:0] serial5_in, serial5_ff, serial6_ff, serial7_ff, serial8_ff;
   logic        valid5_ff, valid6_ff, valid7_ff, valid8_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         day1_ff   <= day_in;
         month1_ff <= month_in;
         year1_ff  <= year_in;
      end
   end

   always_comb begin
      dy2_in       = year1_ff - BASE;
      yprod2_in    = 32'(year1_ff) * 32'(gsdc_pkg::RECIP_100);
      dprod2_in    = 32'(dy2_in) * 32'(gsdc_pkg::RECIP_100);
      month_ok2_in = (month1_ff >= 4'd1) && (month1_ff <= 4'(gsdc_pkg::MONTHS));
      year_ok2_in  = (year1_ff >= BASE) && ({3'b000, year1_ff} <= MAX_YEAR_W);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         day2_ff      <= day1_ff;
         month2_ff    <= month1_ff;
         year2_ff     <= year1_ff;
         dy2_ff       <= dy2_in;
         yprod2_ff    <= yprod2_in;
         dprod2_ff    <= dprod2_in;
         month_ok2_ff <= month_ok2_in;
         year_ok2_ff  <= year_ok2_in;
      end
   end

   always_comb begin
      yq_est   = yprod2_ff[31:24];
      yrem_est = year2_ff - 14'(yq_est) * CENTURY;
      if (yrem_est >= CENTURY) begin
         yq   = yq_est + 8'd1;
         yrem = yrem_est - CENTURY;
      end else begin
         yq   = yq_est;
         yrem = yrem_est;
      end
      dq_est   = dprod2_ff[31:24];
      drem_est = dy2_ff - 14'(dq_est) * CENTURY;
      dq3_in   = (drem_est >= CENTURY) ? dq_est + 8'd1 : dq_est;
      leap3_in = (year2_ff[1:0] == 2'b00) && ((yrem != 14'd0) || (yq[1:0] == 2'b00));
      valid3_in = month_ok2_ff && year_ok2_ff && (day2_ff != 5'd0) &&
                  (day2_ff <= gsdc_pkg::month_days(month2_ff, leap3_in));
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         leap3_ff  <= leap3_in;
         valid3_ff <= valid3_in;
         month3_ff <= month2_ff;
         day3_ff   <= day2_ff;
         dy3_ff    <= dy2_ff;
         dq3_ff    <= dq3_in;
      end
   end

   always_comb begin
      base4_in = 23'(dy3_ff) * 23'(gsdc_pkg::DAYS_1) + 23'(dy3_ff >> 2)
               - 23'(dq3_ff) + 23'(dq3_ff >> 2);
      doy4_in  = gsdc_pkg::days_before_month(month3_ff, leap3_ff) + 9'(day3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         base4_ff  <= base4_in;
         doy4_ff   <= doy4_in;
         valid4_ff <= valid3_ff;
      end
   end

   assign serial5_in = base4_ff + 23'(doy4_ff);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         serial5_ff <= serial5_in;
         valid5_ff  <= valid4_ff;
      end
      if (en[6]) begin
         serial6_ff <= serial5_ff;
         valid6_ff  <= valid5_ff;
      end
      if (en[7]) begin
         serial7_ff <= serial6_ff;
         valid7_ff  <= valid6_ff;
      end
      if (en[8]) begin
         serial8_ff <= serial7_ff;
         valid8_ff  <= valid7_ff;
      end
   end

   always_comb begin
      result.bad    = !valid8_ff;
      result.serial = valid8_ff ? serial8_ff[gsdc_pkg::SERIAL_W-1:0] : '0;
   end

endmodule
`default_nettype wire

>>> rtl/gsdc_decode.sv
// Serial day number to date pipeline: 400-, 100-, 4- and 1-year splits, then month search.
`timescale 1ns / 1ps
`default_nettype none
module gsdc_decode #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  wire logic                                clock,
   input  wire logic [gsdc_pkg::DATA_STAGES:1]      en,
   input  wire logic [gsdc_pkg::SERIAL_W-1:0]       serial_in,
   output gsdc_pkg::dec_result_type                 result
);

   localparam longint unsigned SPAN      = longint'(MAX_YEAR) - longint'(gsdc_pkg::BASE_YEAR)
                                           + 64'd1;
   localparam longint unsigned LAST_DAYS = SPAN * 365 + SPAN / 4 - SPAN / 100 + SPAN / 400;
   localparam logic [25:0]     LAST_SERIAL = 26'(LAST_DAYS);

   // stage 1
   logic [21:0] serial1_ff;

   // stage 2
   logic [21:0] n2_in, n2_ff;
   logic [44:0] prod2_in, prod2_ff;
   logic        bad2_in, bad2_ff;

   // stage 3
   logic [4:0]  q400_est, q400_3_in, q400_3_ff;
   logic [21:0] r400_est;
   logic [17:0] r3_in, r3_ff;
   logic        bad3_ff;

   // stage 4
   logic [1:0]  c100_4_in, c100_4_ff;
   logic [15:0] r4_in, r4_ff;
   logic [4:0]  q400_4_ff;
   logic        bad4_ff;

   // stage 5
   logic [37:0] prod5_in, prod5_ff;
   logic [15:0] r5_ff;
   logic [4:0]  q400_5_ff;
   logic [1:0]  c100_5_ff;
   logic        bad5_ff;

   // stage 6
   logic [4:0]  c4_est, c4_6_in, c4_6_ff;
   logic [15:0] r4y_est;
   logic [10:0] r6_in, r6_ff;
   logic [4:0]  q400_6_ff;
   logic [1:0]  c100_6_ff;
   logic        bad6_ff;

   // stage 7
   logic [1:0]  c1;
   logic [8:0]  doy7_in, doy7_ff;
   logic        leap7_in, leap7_ff;
   logic [13:0] year7_in, year7_ff;
   logic        bad7_ff;

   // stage 8
   logic [3:0]  month8_in, month8_ff;
   logic [8:0]  cum8_in, cum8_ff, doy8_ff;
   logic [13:0] year8_ff;
   logic        bad8_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         serial1_ff <= serial_in;
      end
   end

   always_comb begin
      n2_in    = serial1_ff - 22'd1;
      prod2_in = 45'(n2_in) * 45'(gsdc_pkg::RECIP_400Y);
      bad2_in  = (serial1_ff == 22'd0) || ({4'b0000, serial1_ff} > LAST_SERIAL);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         n2_ff    <= n2_in;
         prod2_ff <= prod2_in;
         bad2_ff  <= bad2_in;
      end
   end

   always_comb begin
      q400_est = prod2_ff[44:40];
      r400_est = n2_ff - 22'(q400_est) * 22'(gsdc_pkg::DAYS_400);
      if (r400_est >= 22'(gsdc_pkg::DAYS_400)) begin
         q400_3_in = q400_est + 5'd1;
         r3_in     = 18'(r400_est - 22'(gsdc_pkg::DAYS_400));
      end else begin
         q400_3_in = q400_est;
         r3_in     = 18'(r400_est);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         q400_3_ff <= q400_3_in;
         r3_ff     <= r3_in;
         bad3_ff   <= bad2_ff;
      end
   end

   always_comb begin
      if (r3_ff >= 18'(3 * gsdc_pkg::DAYS_100)) begin
         c100_4_in = 2'd3;
      end else if (r3_ff >= 18'(2 * gsdc_pkg::DAYS_100)) begin
         c100_4_in = 2'd2;
      end else if (r3_ff >= 18'(gsdc_pkg::DAYS_100)) begin
         c100_4_in = 2'd1;
      end else begin
         c100_4_in = 2'd0;
      end
      r4_in = 16'(r3_ff - 18'(c100_4_in) * 18'(gsdc_pkg::DAYS_100));
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         c100_4_ff <= c100_4_in;
         r4_ff     <= r4_in;
         q400_4_ff <= q400_3_ff;
         bad4_ff   <= bad3_ff;
      end
   end

   assign prod5_in = 38'(r4_ff) * 38'(gsdc_pkg::RECIP_4Y);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         prod5_ff  <= prod5_in;
         r5_ff     <= r4_ff;
         q400_5_ff <= q400_4_ff;
         c100_5_ff <= c100_4_ff;
         bad5_ff   <= bad4_ff;
      end
   end

   always_comb begin
      c4_est  = prod5_ff[36:32];
      r4y_est = r5_ff - 16'(c4_est) * 16'(gsdc_pkg::DAYS_4);
      if (r4y_est >= 16'(gsdc_pkg::DAYS_4)) begin
         c4_6_in = c4_est + 5'd1;
         r6_in   = 11'(r4y_est - 16'(gsdc_pkg::DAYS_4));
      end else begin
         c4_6_in = c4_est;
         r6_in   = 11'(r4y_est);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         c4_6_ff   <= c4_6_in;
         r6_ff     <= r6_in;
         q400_6_ff <= q400_5_ff;
         c100_6_ff <= c100_5_ff;
         bad6_ff   <= bad5_ff;
      end
   end

   always_comb begin
      if (r6_ff >= 11'(3 * gsdc_pkg::DAYS_1)) begin
         c1 = 2'd3;
      end else if (r6_ff >= 11'(2 * gsdc_pkg::DAYS_1)) begin
         c1 = 2'd2;
      end else if (r6_ff >= 11'(gsdc_pkg::DAYS_1)) begin
         c1 = 2'd1;
      end else begin
         c1 = 2'd0;
      end
      doy7_in  = 9'(r6_ff - 11'(c1) * 11'(gsdc_pkg::DAYS_1));
      leap7_in = (c1 == 2'd3) &&
                 ((c4_6_ff != 5'(gsdc_pkg::QUADS_PER_CENTURY - 1)) || (c100_6_ff == 2'd3));
      year7_in = 14'(gsdc_pkg::BASE_YEAR)
               + 14'(q400_6_ff) * 14'(gsdc_pkg::YEARS_400)
               + 14'(c100_6_ff) * 14'(gsdc_pkg::YEARS_100)
               + 14'({c4_6_ff, 2'b00})
               + 14'(c1);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         doy7_ff  <= doy7_in;
         leap7_ff <= leap7_in;
         year7_ff <= year7_in;
         bad7_ff  <= bad6_ff;
      end
   end

   always_comb begin
      month8_in = 4'd1;
      for (int k = 2; k <= gsdc_pkg::MONTHS; k++) begin
         if (doy7_ff >= gsdc_pkg::days_before_month(4'(k), leap7_ff)) begin
            month8_in = month8_in + 4'd1;
         end
      end
      cum8_in = gsdc_pkg::days_before_month(month8_in, leap7_ff);
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         month8_ff <= month8_in;
         cum8_ff   <= cum8_in;
         doy8_ff   <= doy7_ff;
         year8_ff  <= year7_ff;
         bad8_ff   <= bad7_ff;
      end
   end

   always_comb begin
      result.bad   = bad8_ff;
      result.day   = bad8_ff ? '0 : 5'(doy8_ff - cum8_ff + 9'd1);
      result.month = bad8_ff ? '0 : month8_ff;
      result.year  = bad8_ff ? '0 : year8_ff;
   end

endmodule
`default_nettype wire

>>> rtl/gsdc_checker.sv
// Port-level checks on the converter's response channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gsdc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [gsdc_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [gsdc_pkg::SERIAL_W-1:0]     rsp_serial_out,
   input wire logic [gsdc_pkg::DAY_W-1:0]        rsp_day_out,
   input wire logic [gsdc_pkg::MONTH_W-1:0]      rsp_month_out,
   input wire logic [gsdc_pkg::YEAR_W-1:0]       rsp_year_out
);

   localparam logic [gsdc_pkg::STATUS_W-1:0] ST_OK         = gsdc_pkg::STATUS_OK;
   localparam logic [gsdc_pkg::STATUS_W-1:0] ST_BAD_DATE   = gsdc_pkg::STATUS_BAD_DATE;
   localparam logic [gsdc_pkg::STATUS_W-1:0] ST_BAD_SERIAL = gsdc_pkg::STATUS_BAD_SERIAL;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_BAD_DATE) ||
                    (rsp_status == ST_BAD_SERIAL))
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_serial_out == '0) && (rsp_day_out == '0) &&
         (rsp_month_out == '0) && (rsp_year_out == '0))
      else $error("error result carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |->
         ((rsp_serial_out != '0) != (rsp_month_out != '0)) &&
         ((rsp_month_out != '0) == (rsp_day_out != '0)) &&
         ((rsp_month_out != '0) == (rsp_year_out != '0)))
      else $error("ok result mixes encode and decode fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_serial_out) && $stable(rsp_day_out) &&
         $stable(rsp_month_out) && $stable(rsp_year_out))
      else $error("stalled response changed");

endmodule

bind gregorian_serial_day_converter_top gsdc_checker u_gsdc_checker (.*);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the Gregorian serial day converter.
`timescale 1ns / 1ps
module tb;

   localparam int unsigned EPOCH_YEAR       = 1601;
   localparam int unsigned LAST_YEAR        = 9999;
   localparam int unsigned YEAR_SPAN        = LAST_YEAR - EPOCH_YEAR + 1;
   localparam int unsigned LAST_SERIAL      = YEAR_SPAN * 365 + YEAR_SPAN / 4
                                              - YEAR_SPAN / 100 + YEAR_SPAN / 400;
   localparam int unsigned SERIAL_ALL_ONES  = (1 << gsdc_pkg::SERIAL_W) - 1;
   localparam int unsigned YEAR_ALL_ONES    = (1 << gsdc_pkg::YEAR_W) - 1;
   localparam int unsigned PHASES           = 5;
   localparam int unsigned RANDOM_PER_PHASE = 350;
   localparam int unsigned DRAIN_CYCLES     = 40;
   localparam int unsigned LIMIT_CYCLES     = 200000;
   localparam int unsigned MAX_REPORTS      = 10;

   localparam int unsigned SEND_IDLE_PCT[PHASES] = '{0, 56, 0, 23, 0};
   localparam int unsigned RECV_STALL_PCT[PHASES] = '{0, 0, 56, 23, 0};
   localparam int unsigned EDGE_YEARS[8] = '{1601, 1604, 1700, 1900, 2000, 2400, 9996, 9999};
   localparam int unsigned NORMAL_MONTH_LEN[12] = '{31, 28, 31, 30, 31, 30,
                                                    31, 31, 30, 31, 30, 31};

   typedef struct {
      logic                          kind;
      logic [gsdc_pkg::DAY_W-1:0]    day;
      logic [gsdc_pkg::MONTH_W-1:0]  month;
      logic [gsdc_pkg::YEAR_W-1:0]   year;
      logic [gsdc_pkg::SERIAL_W-1:0] serial;
   } date_req_type;

   typedef struct {
      gsdc_pkg::status_type          status;
      logic [gsdc_pkg::SERIAL_W-1:0] serial;
      logic [gsdc_pkg::DAY_W-1:0]    day;
      logic [gsdc_pkg::MONTH_W-1:0]  month;
      logic [gsdc_pkg::YEAR_W-1:0]   year;
   } date_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_type = gsdc_pkg::REQ_ENCODE;
   logic [gsdc_pkg::DAY_W-1:0]    req_day_in = '0;
   logic [gsdc_pkg::MONTH_W-1:0]  req_month_in = '0;
   logic [gsdc_pkg::YEAR_W-1:0]   req_year_in = '0;
   logic [gsdc_pkg::SERIAL_W-1:0] req_serial_in = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [gsdc_pkg::STATUS_W-1:0] rsp_status;
   logic [gsdc_pkg::SERIAL_W-1:0] rsp_serial_out;
   logic [gsdc_pkg::DAY_W-1:0]    rsp_day_out;
   logic [gsdc_pkg::MONTH_W-1:0]  rsp_month_out;
   logic [gsdc_pkg::YEAR_W-1:0]   rsp_year_out;

   date_req_type queued_requests[$];
   date_rsp_type awaited_conversions[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned encodes_sent = 0;
   int unsigned decodes_sent = 0;
   int unsigned error_statuses = 0;
   int unsigned results_checked = 0;

   gregorian_serial_day_converter_top #(
      .MAX_YEAR(LAST_YEAR)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_day_in(req_day_in),
      .req_month_in(req_month_in),
      .req_year_in(req_year_in),
      .req_serial_in(req_serial_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_serial_out(rsp_serial_out),
      .rsp_day_out(rsp_day_out),
      .rsp_month_out(rsp_month_out),
      .rsp_year_out(rsp_year_out)
   );

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic int unsigned month_length(int unsigned m, int unsigned y);
      if (m < 1 || m > 12) begin
         return 31;
      end
      if (m == 2 && leap_year(y)) begin
         return 29;
      end
      return NORMAL_MONTH_LEN[m - 1];
   endfunction

   function automatic int unsigned days_ahead(int unsigned years);
      return years * 365 + years / 4 - years / 100 + years / 400;
   endfunction

   function automatic date_rsp_type convert_date(date_req_type r);
      date_rsp_type e;
      int unsigned  d;
      int unsigned  m;
      int unsigned  y;
      int unsigned  s;
      int unsigned  dy;
      int unsigned  left;
      int unsigned  i;
      e.status = gsdc_pkg::STATUS_OK;
      e.serial = '0;
      e.day    = '0;
      e.month  = '0;
      e.year   = '0;
      if (r.kind == gsdc_pkg::REQ_ENCODE) begin
         d = r.day;
         m = r.month;
         y = r.year;
         if (m < 1 || m > 12 || y < EPOCH_YEAR || y > LAST_YEAR || d < 1
             || d > month_length(m, y)) begin
            e.status = gsdc_pkg::STATUS_BAD_DATE;
         end else begin
            s = days_ahead(y - EPOCH_YEAR) + d;
            for (i = 1; i < m; i++) begin
               s += month_length(i, y);
            end
            e.serial = s;
         end
      end else begin
         s = r.serial;
         if (s == 0 || s > LAST_SERIAL) begin
            e.status = gsdc_pkg::STATUS_BAD_SERIAL;
         end else begin
            dy = s / 365;
            while (dy > 0 && days_ahead(dy) >= s) begin
               dy--;
            end
            left = s - days_ahead(dy);
            y = dy + EPOCH_YEAR;
            m = 1;
            while (m < 12 && left > month_length(m, y)) begin
               left -= month_length(m, y);
               m++;
            end
            e.day   = left;
            e.month = m;
            e.year  = y;
         end
      end
      return e;
   endfunction

   function automatic date_req_type make_req(logic kind, int unsigned d, int unsigned m,
                                             int unsigned y, int unsigned s);
      date_req_type r;
      r.kind   = kind;
      r.day    = d;
      r.month  = m;
      r.year   = y;
      r.serial = s;
      return r;
   endfunction

   function automatic date_req_type random_request();
      date_req_type r;
      int unsigned  pick;
      int unsigned  y;
      int unsigned  m;
      int unsigned  len;
      r = make_req(gsdc_pkg::REQ_ENCODE, $urandom_range(31), $urandom_range(15),
                   $urandom_range(YEAR_ALL_ONES), $urandom_range(SERIAL_ALL_ONES));
      pick = $urandom_range(99);
      if (pick < 40) begin
         y = ($urandom_range(3) == 0) ? EDGE_YEARS[$urandom_range(7)]
                                      : $urandom_range(LAST_YEAR, EPOCH_YEAR);
         m = $urandom_range(12, 1);
         len = month_length(m, y);
         r.year  = y;
         r.month = m;
         r.day   = ($urandom_range(3) == 0) ? len : $urandom_range(len, 1);
      end else if (pick < 55) begin
         y = $urandom_range(LAST_YEAR, EPOCH_YEAR);
         m = $urandom_range(12, 1);
         case ($urandom_range(2))
            0: begin
               r.year  = y;
               r.month = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 13);
            end
            1: begin
               r.year  = y;
               r.month = m;
               r.day   = ($urandom_range(3) == 0) ? 0 : $urandom_range(31, month_length(m, y));
               if (r.day == month_length(m, y)) begin
                  r.day = r.day + 1;
               end
            end
            default: begin
            end
         endcase
      end else if (pick < 90) begin
         r.kind = gsdc_pkg::REQ_DECODE;
         if ($urandom_range(3) == 0) begin
            r.serial = days_ahead($urandom_range(YEAR_SPAN - 1, 1)) + $urandom_range(1);
         end else begin
            r.serial = $urandom_range(LAST_SERIAL, 1);
         end
      end else begin
         r.kind = gsdc_pkg::REQ_DECODE;
         case ($urandom_range(2))
            0: r.serial = 0;
            1: r.serial = $urandom_range(SERIAL_ALL_ONES, LAST_SERIAL + 1);
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic note_fault(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_conversions.size());
         $display("[gregorian_serial_day_converter_top] ERROR");
         $finish;
      end
   end

   // Driver: record each transfer's prediction, then present the next request or idle
   always @(posedge clock) begin
      date_req_type nxt;
      date_rsp_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            e = convert_date(make_req(req_type, req_day_in, req_month_in, req_year_in,
                                      req_serial_in));
            awaited_conversions.push_back(e);
            if (req_type == gsdc_pkg::REQ_ENCODE) begin
               encodes_sent++;
            end else begin
               decodes_sent++;
            end
            if (e.status != gsdc_pkg::STATUS_OK) begin
               error_statuses++;
            end
         end
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = queued_requests.pop_front();
               req_type      <= nxt.kind;
               req_day_in    <= nxt.day;
               req_month_in  <= nxt.month;
               req_year_in   <= nxt.year;
               req_serial_in <= nxt.serial;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      date_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_conversions.size() == 0) begin
               note_fault($sformatf("unexpected result st=%0d ser=%0d d=%0d m=%0d y=%0d",
                                    rsp_status, rsp_serial_out, rsp_day_out,
                                    rsp_month_out, rsp_year_out));
            end else begin
               e = awaited_conversions.pop_front();
               results_checked++;
               if (rsp_status !== e.status || rsp_serial_out !== e.serial
                   || rsp_day_out !== e.day || rsp_month_out !== e.month
                   || rsp_year_out !== e.year) begin
                  note_fault($sformatf({"mismatch exp st=%0d ser=%0d d=%0d m=%0d y=%0d",
                                        " got st=%0d ser=%0d d=%0d m=%0d y=%0d"},
                                       e.status, e.serial, e.day, e.month, e.year,
                                       rsp_status, rsp_serial_out, rsp_day_out,
                                       rsp_month_out, rsp_year_out));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 1, 1, 1601, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 31, 12, 9999,
                                         SERIAL_ALL_ONES));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 31, 12, 1601, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 29, 2, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 29, 2, 1900, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 29, 2, 2004, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 29, 2, 2003, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 1, 3, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 15, 0, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 15, 13, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 0, 6, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 31, 4, 2000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 31, 12, 1600, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 1, 1, 10000, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_ENCODE, 31, 15, YEAR_ALL_ONES,
                                         SERIAL_ALL_ONES));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 31, 15, YEAR_ALL_ONES, 0));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, 1));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, LAST_SERIAL));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, LAST_SERIAL + 1));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 31, 15, YEAR_ALL_ONES,
                                         SERIAL_ALL_ONES));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, 60));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, 365));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, 366));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0, days_ahead(400)));
      queued_requests.push_back(make_req(gsdc_pkg::REQ_DECODE, 0, 0, 0,
                                         days_ahead(400) + 1));

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = SEND_IDLE_PCT[p];
         recv_stall_pct = RECV_STALL_PCT[p];
         repeat (RANDOM_PER_PHASE) queued_requests.push_back(random_request());
         while (queued_requests.size() != 0 || req_valid) @(negedge clock);
         // hold new requests until the pipeline has drained
         while (awaited_conversions.size() != 0) @(negedge clock);
      end

      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (awaited_conversions.size() != 0) begin
         note_fault($sformatf("%0d results never arrived", awaited_conversions.size()));
      end
      $display("covered %0d encode and %0d decode transfers, %0d with error status,",
               encodes_sent, decodes_sent, error_statuses);
      $display("%0d results checked over %0d idle/stall phases, %0d mismatches",
               results_checked, PHASES, mismatches);
      if (mismatches == 0) begin
         $display("[gregorian_serial_day_converter_top] OK");
      end else begin
         $display("[gregorian_serial_day_converter_top] ERROR");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/gsdc_pkg.sv
rtl/gsdc_encode.sv
rtl/gsdc_decode.sv
rtl/gregorian_serial_day_converter_top.sv
rtl/gsdc_checker.sv
dv/tb.sv
